/* rtl/gkr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_pkg
// Shared types, constants and the Gaussian weight table for the kernel
// regression core.
// ----------------------------------------------------------------------------
package gkr_pkg;

    localparam int KERNEL_TABLE_SIZE = 256;
    localparam int FRACTION_BITS     = 16;
    localparam int WEIGHT_BITS       = 16;
    localparam int W_W               = WEIGHT_BITS + 1;
    localparam int IDX_W             = $clog2(KERNEL_TABLE_SIZE);
    localparam logic [63:0] LN2_Q32  = 64'd2977044472;
    localparam logic [63:0] TAB_DEN  = 64'(KERNEL_TABLE_SIZE) * 64'(KERNEL_TABLE_SIZE);
    localparam logic [63:0] U_LIMIT  = 64'd4 << FRACTION_BITS;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DIV
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] query_x;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    typedef logic [KERNEL_TABLE_SIZE-1:0][W_W-1:0] t_wtab;

    function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
        logic [63:0] q;
        case (k)
            1:       q = v;
            2:       q = v / 64'd2;
            3:       q = v / 64'd3;
            4:       q = v / 64'd4;
            5:       q = v / 64'd5;
            6:       q = v / 64'd6;
            7:       q = v / 64'd7;
            8:       q = v / 64'd8;
            9:       q = v / 64'd9;
            10:      q = v / 64'd10;
            11:      q = v / 64'd11;
            12:      q = v / 64'd12;
            13:      q = v / 64'd13;
            14:      q = v / 64'd14;
            15:      q = v / 64'd15;
            default: q = v / 64'd16;
        endcase
        return q;
    endfunction

    // exp(-a), argument and result in Q32.
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
        logic [63:0]        n;
        logic [63:0]        r;
        logic [63:0]        term;
        logic signed [65:0] sum;
        n    = a / LN2_Q32;
        r    = a - n * LN2_Q32;
        term = 64'd1 << 32;
        sum  = 66'sd1 <<< 32;
        for (int k = 1; k <= 16; k++) begin
            term = div_small((term * r) >> 32, k);
            if (k % 2 == 1) begin
                sum = sum - $signed({2'b00, term});
            end else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (n >= 64'd63) begin
            return 64'd0;
        end
        return sum[63:0] >> n;
    endfunction

    function automatic t_wtab build_wtab();
        t_wtab       t;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] v;
        for (int i = 0; i < KERNEL_TABLE_SIZE; i++) begin
            a = ((64'd8 * 64'(i) * 64'(i)) << 32) / TAB_DEN;
            e = exp_neg_q32(a);
            v = (e + (64'd1 << (31 - WEIGHT_BITS))) >> (32 - WEIGHT_BITS);
            t[i] = v[W_W-1:0];
        end
        return t;
    endfunction

    localparam t_wtab WEIGHT_TABLE = build_wtab();

endpackage
`default_nettype wire

/* rtl/gkr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_front
// Accepts command transactions, drops unused opcodes and holds accepted
// commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gkr_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire  [1:0]            i_op,
    input  wire  [31:0]           i_point_x,
    input  wire  [31:0]           i_point_y,
    input  wire  [31:0]           i_query_x,
    output gkr_pkg::t_cmd_head    o_head,
    input  wire                   i_pop
);

    gkr_pkg::t_cmd r_q [2];
    logic [1:0]    r_cnt;
    logic          r_rd;
    logic          r_wr;
    logic          accept;
    logic          keep;
    logic          pop;

    assign busy   = (r_cnt == 2'd2);
    assign accept = start && !busy;
    assign pop    = i_pop && (r_cnt != 2'd0);

    always_comb begin
        unique case (gkr_pkg::t_op'(i_op))
            gkr_pkg::OP_CLEAR, gkr_pkg::OP_APPEND, gkr_pkg::OP_QUERY: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_q[r_wr] <= '{op: gkr_pkg::t_op'(i_op), point_x: i_point_x,
                           point_y: i_point_y, query_x: i_query_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (accept && keep) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(accept && keep) - 2'(pop);
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rd];

endmodule
`default_nettype wire

/* rtl/gkr_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gkr_div #(
    parameter int NW = 66,
    parameter int DW = 29
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [NW-1:0] i_num,
    input  wire  [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [DW:0]    r_rem;
    logic [NW-1:0]  r_quo;
    logic [DW-1:0]  r_den;
    logic [CNT_W-1:0] r_cnt;
    logic           r_run;
    logic [DW:0]    shifted;
    logic           fits;

    assign shifted = {r_rem[DW-1:0], r_quo[NW-1]};
    assign fits    = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_run) begin
            r_rem <= fits ? shifted - {1'b0, r_den} : shifted;
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_quo;

endmodule
`default_nettype wire

/* rtl/gkr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkr_back
// Executes queued commands: owns the sample store, walks it through a
// weight pipeline for queries and finishes each query with a division.
// ----------------------------------------------------------------------------
module gkr_back #(
    parameter int MAX_POINTS = 1024
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [31:0]           i_inv_bw,
    input  gkr_pkg::t_cmd_head    i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [31:0]           o_estimate,
    output logic                  o_no_support
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int W_W   = gkr_pkg::W_W;
    localparam int WY_W  = W_W + 1 + 32;
    localparam int SUM_W = WY_W + CW;
    localparam int WS_W  = W_W + CW;
    localparam int NW    = SUM_W + 1;
    localparam int FB    = gkr_pkg::FRACTION_BITS;

    logic [31:0] r_mem_x [MAX_POINTS];
    logic [31:0] r_mem_y [MAX_POINTS];

    gkr_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_idx;
    logic [31:0]     r_qx;

    logic                   r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [31:0]            r_x1, r_y1, r_y2, r_y3, r_y4;
    logic [32:0]            r_mag;
    logic [63:0]            r_prod;
    logic [W_W-1:0]         r_w4, r_w5;
    logic signed [WY_W-1:0] r_wy;
    logic [WS_W-1:0]        r_wsum;
    logic signed [SUM_W-1:0] r_wysum;
    logic                   r_neg;

    logic signed [32:0] diff;
    logic [63:0]        uq;
    logic [63:0]        tidx;
    logic [W_W-1:0]     w_next;
    logic [SUM_W-1:0]   abs_wy;
    logic [NW-1:0]      num;
    logic               div_start;
    logic               div_done;
    logic [NW-1:0]      quo;
    logic               walk_last;
    logic               pipe_busy;

    assign diff      = $signed({r_qx[31], r_qx}) - $signed({r_x1[31], r_x1});
    assign uq        = r_prod >> FB;
    assign tidx      = (uq * 64'(gkr_pkg::KERNEL_TABLE_SIZE)) >> (FB + 2);
    assign w_next    = (uq >= gkr_pkg::U_LIMIT) ? '0
                     : gkr_pkg::WEIGHT_TABLE[tidx[gkr_pkg::IDX_W-1:0]];
    assign walk_last = ({1'b0, r_idx} == CW'(r_count - 1'b1));
    assign pipe_busy = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign abs_wy    = r_wysum[SUM_W-1] ? SUM_W'(-r_wysum) : SUM_W'(r_wysum);
    assign num       = {1'b0, abs_wy} + NW'(r_wsum >> 1);
    assign div_start = (r_state == gkr_pkg::ST_DRAIN) && !pipe_busy && (r_wsum != '0);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            gkr_pkg::ST_IDLE: begin
                o_pop = i_head.valid;
                if (i_head.valid && i_head.cmd.op == gkr_pkg::OP_QUERY && r_count != '0) begin
                    n_state = gkr_pkg::ST_WALK;
                end
            end
            gkr_pkg::ST_WALK: begin
                if (walk_last) begin
                    n_state = gkr_pkg::ST_DRAIN;
                end
            end
            gkr_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = (r_wsum == '0) ? gkr_pkg::ST_IDLE : gkr_pkg::ST_DIV;
                end
            end
            gkr_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = gkr_pkg::ST_IDLE;
                end
            end
            default: n_state = gkr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gkr_pkg::ST_IDLE && i_head.valid && i_head.cmd.op == gkr_pkg::OP_APPEND
            && r_count < CW'(MAX_POINTS)) begin
            r_mem_x[r_count[AW-1:0]] <= i_head.cmd.point_x;
            r_mem_y[r_count[AW-1:0]] <= i_head.cmd.point_y;
        end
        r_x1 <= r_mem_x[r_idx];
        r_y1 <= r_mem_y[r_idx];
    end

    // Weight pipeline payload.
    always_ff @(posedge i_clk) begin
        r_mag  <= diff[32] ? 33'(-diff) : 33'(diff);
        r_y2   <= r_y1;
        r_prod <= r_mag[32] ? {i_inv_bw, 32'd0} : r_mag[31:0] * i_inv_bw;
        r_y3   <= r_y2;
        r_w4   <= w_next;
        r_y4   <= r_y3;
        r_wy   <= $signed({1'b0, r_w4}) * $signed(r_y4);
        r_w5   <= r_w4;
        if (r_state == gkr_pkg::ST_IDLE) begin
            r_qx <= i_head.cmd.query_x;
        end
        if (div_start) begin
            r_neg <= r_wysum[SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gkr_pkg::ST_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_v5         <= 1'b0;
            r_wsum       <= '0;
            r_wysum      <= '0;
            o_valid      <= 1'b0;
            o_estimate   <= '0;
            o_no_support <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == gkr_pkg::ST_WALK);
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            o_valid <= 1'b0;
            if (r_v5) begin
                r_wsum  <= r_wsum + WS_W'(r_w5);
                r_wysum <= r_wysum + SUM_W'(r_wy);
            end
            unique case (r_state)
                gkr_pkg::ST_IDLE: begin
                    r_idx   <= '0;
                    r_wsum  <= '0;
                    r_wysum <= '0;
                    if (i_head.valid) begin
                        unique case (i_head.cmd.op)
                            gkr_pkg::OP_CLEAR: r_count <= '0;
                            gkr_pkg::OP_APPEND: begin
                                if (r_count < CW'(MAX_POINTS)) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            gkr_pkg::OP_QUERY: begin
                                if (r_count == '0) begin
                                    o_valid      <= 1'b1;
                                    o_estimate   <= '0;
                                    o_no_support <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                gkr_pkg::ST_WALK: r_idx <= r_idx + 1'b1;
                gkr_pkg::ST_DRAIN: begin
                    if (!pipe_busy && r_wsum == '0) begin
                        o_valid      <= 1'b1;
                        o_estimate   <= '0;
                        o_no_support <= 1'b1;
                    end
                end
                gkr_pkg::ST_DIV: begin
                    if (div_done) begin
                        o_valid      <= 1'b1;
                        o_no_support <= 1'b0;
                        if (r_neg) begin
                            o_estimate <= (quo > NW'(33'h0_8000_0000)) ? 32'h8000_0000
                                        : 32'(-quo[31:0]);
                        end else begin
                            o_estimate <= (quo > NW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                                        : quo[31:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    gkr_div #(.NW(NW), .DW(WS_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (r_wsum),
        .o_done  (div_done),
        .o_quo   (quo)
    );

endmodule
`default_nettype wire

/* rtl/gaussian_kernel_regression_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Clear and append pass through the two-entry queue; an empty-store query answers from idle.
// A query over N stored points walks the store through the weight pipeline (one memory
// read per cycle) and then runs the bit-serial divider on an NW-bit numerator, with
// NW = 51 + clog2(MAX_POINTS+1) bits; the core handles one query at a time.
// Results cannot be stalled. Reset is synchronous, active low: store empty,
// inverse bandwidth 1.0 (65536), queue empty.
// ----------------------------------------------------------------------------
// gaussian_kernel_regression_core
// Nadaraya-Watson estimator with a Gaussian kernel over a sample store.
// ----------------------------------------------------------------------------
// A front end accepts command transactions into a two-entry queue, so the host
// may post the next command while a query is running; busy rises only when
// the queue is full. The back end owns the sample memory. A query streams
// every stored point through a six-stage pipeline (read, distance, scale by
// the inverse bandwidth, weight table lookup, weight times value,
// accumulate), then divides the weighted value sum by the weight sum with
// round-to-nearest and clamps to the signed 32-bit range.
module gaussian_kernel_regression_core #(
    parameter int MAX_POINTS = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_op,
    input  wire  [31:0] i_point_x,
    input  wire  [31:0] i_point_y,
    input  wire  [31:0] i_query_x,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata,
    output logic        o_result_valid,
    output logic [31:0] o_estimate,
    output logic        o_no_support
);

    logic [31:0]        r_inv_bw;
    gkr_pkg::t_cmd_head head;
    logic               pop;

    // Inverse bandwidth register; software must write it only while idle, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_bw <= 32'd65536;
        end else if (i_cfg_we) begin
            r_inv_bw <= i_cfg_wdata;
        end
    end

    gkr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_op      (i_op),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_query_x (i_query_x),
        .o_head    (head),
        .i_pop     (pop)
    );

    gkr_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_inv_bw     (r_inv_bw),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_result_valid),
        .o_estimate   (o_estimate),
        .o_no_support (o_no_support)
    );

    // A result with no support always carries a zero estimate.
    a_no_support_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_no_support) |-> (o_estimate == 32'd0))
        else $error("no-support result with nonzero estimate");

    // Reset clears the result strobe on the next cycle.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe after reset");

    // The back end only pops a command the queue actually holds.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("pop from empty command queue");

endmodule
`default_nettype wire

/* sim/gaussian_kernel_regression_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_kernel_regression_core_test
// Self-checking bench for the kernel regression core. Command transactions
// come from a queue that the stimulus process fills. A behavioral predictor
// keeps its own sample store and weight table and works out each query
// estimate. A monitor checks every result strobe against the oldest
// prediction. The inverse bandwidth is rewritten between phases while the
// core is idle.
// ----------------------------------------------------------------------------
module gaussian_kernel_regression_core_test;

    localparam int          STORE_DEPTH = 1024;
    localparam int          GAUSS_SIZE  = 256;
    localparam int          FRAC        = 16;
    localparam int          WATCHDOG    = 20000;
    localparam int          BIG_STORE   = 200;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam longint unsigned LN2_FIX = 64'd2977044472;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] qx;
    } t_pending;

    typedef struct {
        logic [31:0] estimate;
        logic        no_support;
    } t_answer;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  i_op        = '0;
    logic [31:0] i_point_x   = '0;
    logic [31:0] i_point_y   = '0;
    logic [31:0] i_query_x   = '0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        busy;
    logic        o_result_valid;
    logic [31:0] o_estimate;
    logic        o_no_support;

    gaussian_kernel_regression_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_query_x      (i_query_x),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_estimate     (o_estimate),
        .o_no_support   (o_no_support)
    );

    always #2 i_clk = ~i_clk;

    // Pending commands, the transaction being offered, and predicted answers.
    t_pending cmd_fifo[$];
    t_pending offered;
    t_answer  answer_fifo[$];
    int       hold_off   = 0;
    int       errors     = 0;
    int       n_accepted = 0;
    int       n_queries  = 0;
    int       n_settings = 1;
    int       quiet      = 0;

    // Predictor state: its own copy of the store and the bandwidth register.
    logic [31:0] ib_model = 32'd65536;
    logic [31:0] pos_model[STORE_DEPTH];
    logic [31:0] val_model[STORE_DEPTH];
    int          count_model = 0;
    logic [31:0] gauss_weight[GAUSS_SIZE];

    // exp(-a) with the argument and the result in Q32, by range reduction
    // over ln2 and a truncated Taylor series.
    function automatic longint unsigned exp_neg_fix(longint unsigned a);
        longint unsigned n;
        longint unsigned r;
        longint unsigned term;
        longint          acc;
        n    = a / LN2_FIX;
        r    = a - n * LN2_FIX;
        term = 64'd1 << 32;
        acc  = 64'sd1 <<< 32;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * r) >> 32) / longint'(k);
            if (k % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (n >= 63) return 0;
        return longint'(unsigned'(acc)) >> n;
    endfunction

    initial begin
        longint unsigned a;
        for (int i = 0; i < GAUSS_SIZE; i++) begin
            a = ((64'd8 * i * i) << 32) / (GAUSS_SIZE * GAUSS_SIZE);
            gauss_weight[i] = 32'((exp_neg_fix(a) + (64'd1 << 15)) >> 16);
        end
    end

    function automatic longint unsigned weight_of(longint diff);
        longint unsigned mag;
        longint unsigned uq;
        mag = diff < 0 ? longint'(-diff) : longint'(diff);
        uq  = (mag * longint'({32'd0, ib_model})) >> FRAC;
        if (uq >= (64'd4 << FRAC)) return 0;
        return gauss_weight[(uq * GAUSS_SIZE) >> (FRAC + 2)];
    endfunction

    function automatic t_answer estimate_query(logic [31:0] qx);
        t_answer         ans;
        longint unsigned wsum;
        longint          wysum;
        longint unsigned w;
        longint unsigned mag;
        longint unsigned q;
        wsum  = 0;
        wysum = 0;
        for (int i = 0; i < count_model; i++) begin
            w = weight_of(longint'($signed(qx)) - longint'($signed(pos_model[i])));
            wsum  += w;
            wysum += longint'(w) * longint'($signed(val_model[i]));
        end
        if (wsum == 0) begin
            ans.estimate   = '0;
            ans.no_support = 1'b1;
            return ans;
        end
        mag = wysum < 0 ? longint'(-wysum) : longint'(wysum);
        q   = (mag + wsum / 2) / wsum;
        if (wysum < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            ans.estimate = 32'(-longint'(q));
        end else begin
            if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
            ans.estimate = 32'(q);
        end
        ans.no_support = 1'b0;
        return ans;
    endfunction

    // Apply one accepted command to the predictor.
    task automatic track_command(t_pending c);
        case (c.op)
            gkr_pkg::OP_CLEAR: begin
                count_model = 0;
            end
            gkr_pkg::OP_APPEND: begin
                if (count_model < STORE_DEPTH) begin
                    pos_model[count_model] = c.px;
                    val_model[count_model] = c.py;
                    count_model++;
                end
            end
            gkr_pkg::OP_QUERY: begin
                answer_fifo = {answer_fifo, estimate_query(c.qx)};
                n_queries++;
            end
            default: ;
        endcase
    endtask

    // Driver: one transaction is offered at a time, with a random gap
    // before the next. Start gets exactly one assignment per edge.
    always @(posedge i_clk) begin
        logic next_start;
        int   roll;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                track_command(offered);
                n_accepted++;
                next_start = 1'b0;
                roll = $urandom_range(0, 99);
                if (roll < 65)      hold_off = 0;
                else if (roll < 93) hold_off = $urandom_range(1, 3);
                else                hold_off = $urandom_range(10, 40);
            end
            if (!next_start) begin
                if (hold_off > 0) begin
                    hold_off--;
                end else if (cmd_fifo.size() > 0) begin
                    offered    = cmd_fifo.pop_front();
                    i_op      <= offered.op;
                    i_point_x <= offered.px;
                    i_point_y <= offered.py;
                    i_query_x <= offered.qx;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Monitor: results cannot be held off, so each strobe is checked now.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_result_valid) begin
            if (answer_fifo.size() == 0) begin
                $error("unexpected result: estimate %h no_support %b",
                       o_estimate, o_no_support);
                errors++;
            end else begin
                exp_ans = answer_fifo.pop_front();
                if (o_estimate !== exp_ans.estimate) begin
                    $error("estimate: expected %h, actual %h", exp_ans.estimate, o_estimate);
                    errors++;
                end
                if (o_no_support !== exp_ans.no_support) begin
                    $error("no_support: expected %b, actual %b",
                           exp_ans.no_support, o_no_support);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("gaussian_kernel_regression_core_test: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_cmd(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                            logic [31:0] qx);
        t_pending c;
        c.op = op;
        c.px = px;
        c.py = py;
        c.qx = qx;
        cmd_fifo = {cmd_fifo, c};
    endtask

    // Wait until every command is taken and every answer is in. Commands
    // without a result may still be in the core's queue, so the task then
    // goes on waiting for them to drain.
    task automatic settle();
        while (cmd_fifo.size() > 0 || start || hold_off > 0 || answer_fifo.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_bandwidth(logic [31:0] value);
        settle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        ib_model     = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_settings++;
    endtask

    // Random phase: mostly appends and queries clustered inside the
    // kernel's reach for the current bandwidth, plus some noise.
    task automatic random_phase(int n_items);
        longint reach;
        longint spread;
        longint center;
        int     roll;
        if (ib_model == 0) reach = 64'd1 << 30;
        else               reach = 64'h4_0000_0000 / ib_model;
        if (reach > (64'd1 << 30)) reach = 64'd1 << 30;
        if (reach < 1) reach = 1;
        spread = reach * 3 / 2;
        center = longint'($signed($urandom_range(0, 32'h3fff_ffff) - 32'h2000_0000));
        push_cmd(gkr_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                push_cmd(gkr_pkg::OP_APPEND,
                         32'(center + longint'($urandom_range(0, 32'(2 * spread))) - spread),
                         $urandom, $urandom);
            end else if (roll < 85) begin
                push_cmd(gkr_pkg::OP_QUERY, $urandom, $urandom,
                         32'(center + longint'($urandom_range(0, 32'(2 * spread))) - spread));
            end else if (roll < 88) begin
                push_cmd(gkr_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
            end else begin
                push_cmd(2'($urandom), $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, far points, extremes, unused opcode, clear.
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, '0);
        push_cmd(gkr_pkg::OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, '0);
        push_cmd(gkr_pkg::OP_APPEND, 32'h7fff_ffff, 32'h8000_0000, '0);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h0000_0000);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h7fff_ffff);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h8000_0000);
        push_cmd(gkr_pkg::OP_APPEND, 32'h7ffe_8000, 32'h0001_0000, '0);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h7fff_0000);
        push_cmd(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h7fff_ffff);
        push_cmd(gkr_pkg::OP_CLEAR,  '0, '0, '0);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h7fff_ffff);
        push_cmd(gkr_pkg::OP_APPEND, 32'h0000_0000, 32'h7fff_ffff, '0);
        push_cmd(gkr_pkg::OP_APPEND, 32'h0000_0000, 32'h7fff_ffff, '0);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h0000_0000);
        push_cmd(gkr_pkg::OP_APPEND, 32'h0000_0000, 32'h8000_0000, '0);
        push_cmd(gkr_pkg::OP_APPEND, 32'h0000_0000, 32'h8000_0000, '0);
        push_cmd(gkr_pkg::OP_APPEND, 32'h0000_0000, 32'h8000_0000, '0);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h0000_8000);

        // Zero inverse bandwidth: every weight is one, so the answer is the mean.
        write_bandwidth(32'd0);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h8000_0000);
        push_cmd(gkr_pkg::OP_APPEND, 32'h1234_5678, 32'h0000_0003, '0);
        push_cmd(gkr_pkg::OP_QUERY,  '0, '0, 32'h7fff_ffff);

        // Large store: a long walk with many points inside the kernel's reach.
        write_bandwidth(32'd65536);
        push_cmd(gkr_pkg::OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < BIG_STORE; i++)
            push_cmd(gkr_pkg::OP_APPEND,
                     32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000,
                     $urandom, '0);
        push_cmd(gkr_pkg::OP_QUERY, '0, '0, 32'h0000_0000);
        push_cmd(gkr_pkg::OP_QUERY, '0, '0, 32'h0002_0000);

        // Random phases across bandwidth settings, extremes included.
        write_bandwidth(32'd1);
        random_phase(40);
        write_bandwidth(32'hffff_ffff);
        random_phase(35);
        write_bandwidth($urandom_range(32'h0000_1000, 32'h0010_0000));
        random_phase(60);
        write_bandwidth($urandom);
        random_phase(50);
        write_bandwidth(32'h0100_0000);
        random_phase(35);
        write_bandwidth(32'd65536);
        random_phase(60);
        write_bandwidth($urandom_range(1, 32'h0000_4000));
        random_phase(35);

        settle();
        repeat (50) @(posedge i_clk);
        $display("covered %0d command transactions, %0d queries, %0d bandwidth settings",
                 n_accepted, n_queries, n_settings);
        if (errors == 0) begin
            $display("gaussian_kernel_regression_core_test: clean");
        end else begin
            $display("gaussian_kernel_regression_core_test: errors");
        end
        $finish;
    end

endmodule
